### hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared definitions for the decimal text to fixed-point converter
// Word layouts of both channels, character codes and default widths.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int unsigned FRACTION_BITS_DEFAULT = 32;
    localparam int unsigned WHOLE_BITS_DEFAULT    = 32;
    localparam int unsigned OUT_BITS              = 32;

    // floor(2^F / 10^(k+1)) is zero for every k at or past this depth, F <= 48
    localparam int unsigned WEIGHT_DEPTH          = 16;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [3:0] RADIX = 4'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_word_t;

    typedef struct packed {
        logic                negative;
        logic [OUT_BITS-1:0] whole_part;
        logic [OUT_BITS-1:0] fraction_part;
        logic                saturated;
    } result_word_t;

endpackage

### hw/rtl/dtf_stream_if.sv
// ----------------------------------------------------------------------------
// dtf_stream_if: valid/ready channel
// Carries one word per handshake; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
interface dtf_stream_if #(
    parameter type word_t = logic
);

    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### hw/rtl/decimal_text_to_fixed_unit.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_unit: decimal text to fixed-point converter
// Parses one character per word; gives sign, saturated whole part and
// binary fraction when a string ends at NUL or at a word marked last.
// ----------------------------------------------------------------------------
//  channel   dir   word             contents
//  chars     in    char_word_t      char_code, end_of_text
//  result    out   result_word_t    negative, whole_part, fraction_part,
//                                   saturated
//
//  One word per cycle sustained, but for an ending word held by a pending
//  result; the word that ends a string passes the input register, then the
//  result register. Per-character update: shift-add by ten on the whole part,
//  digit times a tabled place weight on the fraction.
//  A pending result stalls only a word that would itself end a string.
//  rst_n clears the parser to the leading-blank state with no result held.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_unit #(
    parameter int unsigned FRACTION_BITS = dtf_pkg::FRACTION_BITS_DEFAULT,
    parameter int unsigned WHOLE_BITS    = dtf_pkg::WHOLE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    dtf_stream_if.sink   chars,
    dtf_stream_if.source result
);

    import dtf_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(WEIGHT_DEPTH + 1);
    localparam int unsigned IDX_BITS = $clog2(WEIGHT_DEPTH);
    localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = '1;

    typedef enum logic [1:0] {PH_LEAD, PH_PARSE, PH_STOP} phase_t;

    logic [FRACTION_BITS-1:0] weight_tab [WEIGHT_DEPTH];

    for (genvar k = 0; k < WEIGHT_DEPTH; k++) begin : g_weight
        localparam logic [63:0] W = (64'd1 << FRACTION_BITS) / (64'd10 ** (k + 1));
        assign weight_tab[k] = W[FRACTION_BITS-1:0];
    end

    // input stage
    logic       in_valid_reg, in_valid_next;
    char_word_t in_word_reg,  in_word_next;

    // parser state
    phase_t                   phase_reg, phase_next;
    logic                     sign_reg,  sign_next;
    logic [WHOLE_BITS-1:0]    whole_reg, whole_next;
    logic [FRACTION_BITS-1:0] frac_reg,  frac_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic                     point_reg, point_next;
    logic                     ovf_reg,   ovf_next;

    // result stage
    logic         out_valid_reg, out_valid_next;
    result_word_t out_word_reg,  out_word_next;

    logic                     finish;
    logic                     advance;
    logic                     in_ready;
    logic                     is_digit;
    logic                     is_blank;
    logic [3:0]               digit;
    logic [FRACTION_BITS-1:0] weight;
    logic [WHOLE_BITS+3:0]    whole_sum;
    logic [FRACTION_BITS+3:0] frac_sum;

    assign finish   = (in_word_reg.char_code == CHAR_NUL) || in_word_reg.end_of_text;
    assign advance  = in_valid_reg && (!finish || !out_valid_reg || result.ready);
    assign in_ready = !in_valid_reg || advance;

    assign is_digit = (in_word_reg.char_code >= CHAR_ZERO)
                   && (in_word_reg.char_code <= CHAR_NINE);
    assign is_blank = (in_word_reg.char_code == CHAR_SPACE)
                   || (in_word_reg.char_code == CHAR_TAB)
                   || (in_word_reg.char_code == CHAR_NL)
                   || (in_word_reg.char_code == CHAR_MINUS);
    assign digit    = 4'(in_word_reg.char_code - CHAR_ZERO);

    assign weight    = (count_reg < CNT_BITS'(WEIGHT_DEPTH))
                     ? weight_tab[count_reg[IDX_BITS-1:0]] : '0;
    assign whole_sum = (WHOLE_BITS+4)'(whole_reg) * (WHOLE_BITS+4)'(RADIX)
                     + (WHOLE_BITS+4)'(digit);
    assign frac_sum  = (FRACTION_BITS+4)'(frac_reg)
                     + (FRACTION_BITS+4)'(digit) * (FRACTION_BITS+4)'(weight);

    always_comb
    begin
        logic do_parse;

        do_parse      = 1'b0;
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        phase_next    = phase_reg;
        sign_next     = sign_reg;
        whole_next    = whole_reg;
        frac_next     = frac_reg;
        count_next    = count_reg;
        point_next    = point_reg;
        ovf_next      = ovf_reg;
        out_word_next = out_word_reg;

        if (in_ready)
        begin
            in_valid_next = chars.valid;
            in_word_next  = chars.data;
        end

        if (advance && (in_word_reg.char_code != CHAR_NUL))
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (is_blank)
                    begin
                        if (in_word_reg.char_code == CHAR_MINUS)
                        begin
                            sign_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PARSE;
                        do_parse   = 1'b1;
                    end
                end
                PH_PARSE:
                begin
                    do_parse = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (do_parse)
        begin
            if (is_digit)
            begin
                if (point_reg)
                begin
                    frac_next = frac_sum[FRACTION_BITS-1:0];
                    if (count_reg < CNT_BITS'(WEIGHT_DEPTH))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (|whole_sum[WHOLE_BITS+3:WHOLE_BITS])
                begin
                    whole_next = WHOLE_MAX;
                    ovf_next   = 1'b1;
                end
                else
                begin
                    whole_next = whole_sum[WHOLE_BITS-1:0];
                end
            end
            else if ((in_word_reg.char_code == CHAR_POINT) && !point_reg)
            begin
                point_next = 1'b1;
            end
            else
            begin
                phase_next = PH_STOP;
            end
        end

        out_valid_next = out_valid_reg && !result.ready;

        if (advance && finish)
        begin
            out_valid_next              = 1'b1;
            out_word_next.negative      = sign_next;
            out_word_next.whole_part    = OUT_BITS'(whole_next);
            out_word_next.fraction_part = OUT_BITS'(frac_next);
            out_word_next.saturated     = ovf_next;
            phase_next = PH_LEAD;
            sign_next  = 1'b0;
            whole_next = '0;
            frac_next  = '0;
            count_next = '0;
            point_next = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_word_reg   <= '0;
            phase_reg     <= PH_LEAD;
            sign_reg      <= 1'b0;
            whole_reg     <= '0;
            frac_reg      <= '0;
            count_reg     <= '0;
            point_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            in_word_reg   <= in_word_next;
            phase_reg     <= phase_next;
            sign_reg      <= sign_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            count_reg     <= count_next;
            point_reg     <= point_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign chars.ready  = in_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && finish && out_valid_reg && !result.ready |=> in_valid_reg)
        else $error("ending word lost while result pending");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        advance && finish |=> phase_reg == PH_LEAD && whole_reg == '0
                              && !point_reg && !sign_reg && !ovf_reg)
        else $error("parser not cleared after result");

    a_frac_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
        !point_reg |-> frac_reg == '0 && count_reg == '0)
        else $error("fraction moved before decimal point");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> whole_reg == WHOLE_MAX)
        else $error("saturation flag without saturated whole part");

    a_lead_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LEAD |-> whole_reg == '0 && !point_reg && !ovf_reg)
        else $error("digits accumulated in leading blanks");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: decimal text to fixed-point converter
// Streams character words through the unit with random idling on both sides,
// predicts sign, whole part, fraction and saturation per string, and checks
// each result word in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;

    import dtf_pkg::*;

    localparam int          TEXT_WORDS   = 1150;
    localparam int          QUIET_TAIL   = 120;
    localparam int          HOLD_AFTER   = 300;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [31:0] WHOLE_MAX    = 32'hFFFF_FFFF;
    localparam logic [31:0] FIRST_WEIGHT = 32'd429496729;

    typedef enum logic [1:0] {
        SCAN_LEAD    = 2'd0,
        SCAN_DIGITS  = 2'd1,
        SCAN_STOPPED = 2'd2
    } scan_phase_t;

    logic clk;
    logic rst_n;

    dtf_stream_if #(.word_t(char_word_t))   chars_if ();
    dtf_stream_if #(.word_t(result_word_t)) result_if ();

    decimal_text_to_fixed_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    char_word_t   text_queue[$];
    result_word_t expected_fixed[$];

    scan_phase_t scan_phase;
    logic        sign_flag;
    logic        point_flag;
    logic        sat_flag;
    logic [31:0] whole_sum;
    logic [31:0] frac_sum;
    logic [31:0] weight;

    logic char_taken;
    int   words_taken;
    int   mismatch_count;
    int   cycle_count;
    int   send_gap;
    int   stall_left;
    bit   hold_done;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // parser prediction
    function automatic void clear_scan();
        scan_phase = SCAN_LEAD;
        sign_flag  = 1'b0;
        point_flag = 1'b0;
        sat_flag   = 1'b0;
        whole_sum  = '0;
        frac_sum   = '0;
        weight     = FIRST_WEIGHT;
    endfunction

    function automatic void digit_or_stop(logic [7:0] c);
        logic [35:0] grown;
        logic [63:0] frac_next;
        logic [3:0]  d;
        d = c[3:0];
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            if (point_flag)
            begin
                frac_next = 64'(frac_sum) + 64'(d) * 64'(weight);
                frac_sum  = frac_next[31:0];
                weight    = weight / 32'd10;
            end
            else
            begin
                grown = 36'(whole_sum) * 36'd10 + 36'(d);
                if (grown > 36'(WHOLE_MAX))
                begin
                    grown    = 36'(WHOLE_MAX);
                    sat_flag = 1'b1;
                end
                whole_sum = grown[31:0];
            end
        end
        else if (c == CHAR_POINT && !point_flag)
            point_flag = 1'b1;
        else
            scan_phase = SCAN_STOPPED;
    endfunction

    function automatic void predict_fixed(char_word_t w);
        result_word_t r;
        if (w.char_code != CHAR_NUL)
        begin
            if (scan_phase == SCAN_LEAD)
            begin
                if (w.char_code == CHAR_SPACE || w.char_code == CHAR_TAB ||
                    w.char_code == CHAR_NL || w.char_code == CHAR_MINUS)
                begin
                    if (w.char_code == CHAR_MINUS)
                        sign_flag = 1'b1;
                end
                else
                begin
                    scan_phase = SCAN_DIGITS;
                    digit_or_stop(w.char_code);
                end
            end
            else if (scan_phase == SCAN_DIGITS)
                digit_or_stop(w.char_code);
        end
        if (w.char_code == CHAR_NUL || w.end_of_text)
        begin
            r.negative      = sign_flag;
            r.whole_part    = whole_sum;
            r.fraction_part = frac_sum;
            r.saturated     = sat_flag;
            expected_fixed.push_back(r);
            clear_scan();
        end
    endfunction

    function automatic void check_result(result_word_t got);
        result_word_t exp;
        if (expected_fixed.size() == 0)
        begin
            $error("result word with none expected");
            mismatch_count++;
        end
        else
        begin
            exp = expected_fixed.pop_front();
            if (got.negative !== exp.negative)
            begin
                $error("negative: expected %0d, got %0d", exp.negative, got.negative);
                mismatch_count++;
            end
            if (got.whole_part !== exp.whole_part)
            begin
                $error("whole_part: expected %0d, got %0d", exp.whole_part, got.whole_part);
                mismatch_count++;
            end
            if (got.fraction_part !== exp.fraction_part)
            begin
                $error("fraction_part: expected %0d, got %0d",
                       exp.fraction_part, got.fraction_part);
                mismatch_count++;
            end
            if (got.saturated !== exp.saturated)
            begin
                $error("saturated: expected %0d, got %0d", exp.saturated, got.saturated);
                mismatch_count++;
            end
        end
    endfunction

    // stimulus building
    function automatic void push_word(logic [7:0] code, logic last);
        char_word_t w;
        w.char_code   = code;
        w.end_of_text = last;
        text_queue.push_back(w);
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] random_blank();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: c = CHAR_SPACE;
            1: c = CHAR_TAB;
            2: c = CHAR_NL;
            default: c = CHAR_MINUS;
        endcase
        return c;
    endfunction

    function automatic void queue_random_string();
        char_word_t w;
        int kind;
        int start;
        int n;
        kind  = $urandom_range(0, 9);
        start = text_queue.size();
        if (kind == 0)
        begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
                push_word(8'($urandom_range(1, 255)), 1'b0);
        end
        else
        begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                push_word(random_blank(), 1'b0);
            n = (kind == 1) ? $urandom_range(9, 13) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                push_word(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 3) != 0)
            begin
                push_word(CHAR_POINT, 1'b0);
                n = (kind == 2) ? $urandom_range(9, 16) : $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    push_word(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_word(8'($urandom_range(1, 255)), 1'b0);
            end
        end
        if (text_queue.size() > start && $urandom_range(0, 1) == 1)
        begin
            w = text_queue.pop_back();
            w.end_of_text = 1'b1;
            text_queue.push_back(w);
        end
        else
            push_word(CHAR_NUL, 1'($urandom_range(0, 1)));
    endfunction

    // word acceptance, prediction and checking
    always @(posedge clk)
    begin
        if (!rst_n)
            char_taken <= 1'b0;
        else
        begin
            char_taken <= chars_if.valid && chars_if.ready;
            if (chars_if.valid && chars_if.ready)
            begin
                predict_fixed(chars_if.data);
                words_taken <= words_taken + 1;
            end
            if (result_if.valid && result_if.ready)
                check_result(result_if.data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            chars_if.valid <= 1'b0;
        else if (send_gap > 0)
        begin
            chars_if.valid <= 1'b0;
            send_gap = send_gap - 1;
        end
        else if (!chars_if.valid || char_taken)
        begin
            if (text_queue.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                chars_if.valid <= 1'b0;
                send_gap = $urandom_range(0, 16);
            end
            else if (text_queue.size() > 0)
            begin
                chars_if.valid <= 1'b1;
                chars_if.data  <= text_queue.pop_front();
            end
            else
                chars_if.valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the unit up
    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            result_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!hold_done && words_taken >= HOLD_AFTER)
        begin
            result_if.ready <= 1'b0;
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
        end
        else if (text_queue.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        begin
            result_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
            result_if.ready <= 1'b1;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        chars_if.valid  = 1'b0;
        chars_if.data   = '0;
        result_if.ready = 1'b0;
        char_taken      = 1'b0;
        words_taken     = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        send_gap        = 0;
        stall_left      = 0;
        hold_done       = 1'b0;
        clear_scan();

        // empty string, blank negative string, saturation with second point,
        // stray character, NUL carrying the last flag
        push_word(CHAR_NUL, 1'b0);
        queue_text(" \t\n--");
        queue_text("9999999999.09.7");
        push_word(CHAR_ZERO, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(CHAR_NUL, 1'b0);
        push_word(CHAR_NUL, 1'b1);
        while (text_queue.size() < TEXT_WORDS + 25)
            queue_random_string();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_queue.size() > 0 || chars_if.valid)
            @(posedge clk);
        while (expected_fixed.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_stream_if.sv
hw/rtl/decimal_text_to_fixed_unit.sv
tb/sv/testbench.sv
